@@ hw/rtl/gpwb_pkg.sv @@
// shared types, codes and helper functions for the glyph pixel write/blend block
package gpwb_pkg;

   localparam int unsigned CSR_IDX_W = 2;
   localparam int unsigned MODE_W = 3;
   localparam int unsigned PIXEL_W = 32;
   localparam int unsigned MERGE_BIT = 2;
   localparam logic [7:0] CHAN_MAX = 8'd255;

   typedef enum logic [1:0] {
      FMT_A8       = 2'd0,
      FMT_RGB888   = 2'd1,
      FMT_RGBA4444 = 2'd2,
      FMT_RGBA8888 = 2'd3
   } fmt_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_PEN_RED   = 2'd0,
      CSR_PEN_GREEN = 2'd1,
      CSR_PEN_BLUE  = 2'd2,
      CSR_PEN_ALPHA = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic [7:0] alpha;
   } pen_type;

   typedef struct packed {
      logic [MODE_W-1:0]  mode;
      logic [7:0]         coverage;
      logic [PIXEL_W-1:0] old_pixel;
   } req_item_type;

   // item after the coverage stages
   typedef struct packed {
      logic [MODE_W-1:0]  mode;
      logic [PIXEL_W-1:0] old_pixel;
      logic               skip;
      logic [7:0]         m;
      logic [7:0]         inv;
   } mid_item_type;

   typedef struct packed {
      logic [PIXEL_W-1:0] new_pixel;
      logic               changed;
   } rsp_item_type;

   // floor(x / 255), exact for x up to 255 * 255
   function automatic logic [7:0] div255(input logic [15:0] x);
      logic [16:0] t;
      t = {1'b0, x} + {9'd0, x[15:8]} + 17'd1;
      return t[15:8];
   endfunction

   function automatic logic [7:0] quant_pair(input logic [7:0] hi, input logic [7:0] lo);
      return {hi[7:4], lo[7:4]};
   endfunction

   function automatic logic [7:0] sat255(input logic [8:0] v);
      return v[8] ? CHAN_MAX : v[7:0];
   endfunction

   function automatic logic [PIXEL_W-1:0] fmt_mask(input fmt_type f);
      logic [PIXEL_W-1:0] r;
      case (f)
         FMT_A8:       r = 32'h0000_00FF;
         FMT_RGB888:   r = 32'h00FF_FFFF;
         FMT_RGBA4444: r = 32'h0000_FFFF;
         FMT_RGBA8888: r = 32'hFFFF_FFFF;
         default:      r = 32'hFFFF_FFFF;
      endcase
      return r;
   endfunction

endpackage

@@ hw/rtl/gpwb_if.sv @@
// valid/ready channel interfaces for pixel requests, results and pen registers
interface gpwb_req_if
   import gpwb_pkg::*;
();
   logic               valid;
   logic               ready;
   logic [MODE_W-1:0]  mode;
   logic [7:0]         coverage;
   logic [PIXEL_W-1:0] old_pixel;

   modport source (output valid, output mode, output coverage, output old_pixel,
                   input ready);
   modport sink (input valid, input mode, input coverage, input old_pixel,
                 output ready);
endinterface

interface gpwb_rsp_if
   import gpwb_pkg::*;
();
   logic               valid;
   logic               ready;
   logic [PIXEL_W-1:0] new_pixel;
   logic               changed;

   modport source (output valid, output new_pixel, output changed, input ready);
   modport sink (input valid, input new_pixel, input changed, output ready);
endinterface

interface gpwb_csr_if
   import gpwb_pkg::*;
();
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [7:0]           data;

   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

@@ hw/rtl/glyph_pixel_write_blend.sv @@
// top level of the glyph pixel write/blend pipeline
//
//   channel  dir  handshake      payload
//   req      in   valid/ready    mode[2:0], coverage[7:0], old_pixel[31:0]
//   rsp      out  valid/ready    new_pixel[31:0], changed
//   csr      in   valid/ready    index[1:0], data[7:0] (pen red, green, blue, alpha)
//
// four register stages: coverage product, scale by 1/255, channel products,
// divide/saturate/pack; one item per cycle while rsp is ready.
// reset clears the stage valid bits and sets the pen to opaque black.
// a stalled rsp holds each stage that has an item; empty stages still fill,
// so req stays ready until the pipe is full.
module glyph_pixel_write_blend
   import gpwb_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   gpwb_req_if.sink    req,
   gpwb_rsp_if.source  rsp,
   gpwb_csr_if.sink    csr
);

   pen_type      pen;
   req_item_type req_item;
   mid_item_type mid_item;
   logic         mid_valid;
   logic         mid_ready;
   rsp_item_type rsp_item;

   assign req_item.mode = req.mode;
   assign req_item.coverage = req.coverage;
   assign req_item.old_pixel = req.old_pixel;

   assign rsp.new_pixel = rsp_item.new_pixel;
   assign rsp.changed = rsp_item.changed;

   gpwb_csr u_csr (
      .clock (clock),
      .reset (reset),
      .csr   (csr),
      .pen   (pen)
   );

   gpwb_cov u_cov (
      .clock     (clock),
      .reset     (reset),
      .pen       (pen),
      .in_valid  (req.valid),
      .in_ready  (req.ready),
      .in_item   (req_item),
      .out_valid (mid_valid),
      .out_ready (mid_ready),
      .out_item  (mid_item)
   );

   gpwb_blend u_blend (
      .clock     (clock),
      .reset     (reset),
      .pen       (pen),
      .in_valid  (mid_valid),
      .in_ready  (mid_ready),
      .in_item   (mid_item),
      .out_valid (rsp.valid),
      .out_ready (rsp.ready),
      .out_item  (rsp_item)
   );

endmodule

@@ hw/rtl/gpwb_csr.sv @@
// pen color registers
module gpwb_csr
   import gpwb_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   gpwb_csr_if.sink      csr,
   output pen_type       pen
);

   pen_type pen_ff;
   pen_type pen_in;

   assign csr.ready = 1'b1;
   assign pen = pen_ff;

   always_comb begin
      pen_in = pen_ff;
      if (csr.valid) begin
         case (csr_index_type'(csr.index))
            CSR_PEN_RED:   pen_in.red   = csr.data;
            CSR_PEN_GREEN: pen_in.green = csr.data;
            CSR_PEN_BLUE:  pen_in.blue  = csr.data;
            CSR_PEN_ALPHA: pen_in.alpha = csr.data;
            default:       pen_in = pen_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pen_ff <= '{red: 8'd0, green: 8'd0, blue: 8'd0, alpha: CHAN_MAX};
      end else begin
         pen_ff <= pen_in;
      end
   end

endmodule

@@ hw/rtl/gpwb_cov.sv @@
// coverage stages: coverage * pen alpha, then scale to 0..255
module gpwb_cov
   import gpwb_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  pen_type      pen,
   input  logic         in_valid,
   output logic         in_ready,
   input  req_item_type in_item,
   output logic         out_valid,
   input  logic         out_ready,
   output mid_item_type out_item
);

   logic               v1_ff;
   logic               v2_ff;
   logic [MODE_W-1:0]  s1_mode_ff;
   logic [PIXEL_W-1:0] s1_old_ff;
   logic               s1_skip_ff;
   logic [15:0]        s1_prod_ff;
   logic [15:0]        s1_prod_in;
   mid_item_type       s2_ff;
   mid_item_type       s2_in;
   logic               en1;
   logic               en2;

   assign en2 = !v2_ff || out_ready;
   assign en1 = !v1_ff || en2;
   assign in_ready = en1;
   assign out_valid = v2_ff;
   assign out_item = s2_ff;

   assign s1_prod_in = 16'(in_item.coverage) * 16'(pen.alpha);

   always_comb begin
      s2_in.mode = s1_mode_ff;
      s2_in.old_pixel = s1_old_ff;
      s2_in.skip = s1_skip_ff;
      s2_in.m = div255(s1_prod_ff);
      s2_in.inv = CHAN_MAX - s2_in.m;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         if (en1) v1_ff <= in_valid;
         if (en2) v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en1 && in_valid) begin
         s1_mode_ff <= in_item.mode;
         s1_old_ff <= in_item.old_pixel;
         s1_skip_ff <= (in_item.coverage == 8'd0) || (pen.alpha == 8'd0);
         s1_prod_ff <= s1_prod_in;
      end
      if (en2 && v1_ff) begin
         s2_ff <= s2_in;
      end
   end

endmodule

@@ hw/rtl/gpwb_blend.sv @@
// blend stages: channel products, then divide, saturate and pack per format
module gpwb_blend
   import gpwb_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  pen_type      pen,
   input  logic         in_valid,
   output logic         in_ready,
   input  mid_item_type in_item,
   output logic         out_valid,
   input  logic         out_ready,
   output rsp_item_type out_item
);

   logic               v3_ff;
   logic               v4_ff;
   logic [MODE_W-1:0]  s3_mode_ff;
   logic [PIXEL_W-1:0] s3_old_ff;
   logic               s3_skip_ff;
   logic [7:0]         s3_m_ff;
   logic [15:0]        s3_pr_ff;
   logic [15:0]        s3_pg_ff;
   logic [15:0]        s3_pb_ff;
   logic [15:0]        s3_ri_ff;
   logic [15:0]        s3_gi_ff;
   logic [15:0]        s3_bi_ff;
   logic [15:0]        s3_ai_ff;
   rsp_item_type       s4_ff;
   rsp_item_type       s4_in;
   logic               en3;
   logic               en4;
   fmt_type            fmt;
   logic               merge;
   logic [PIXEL_W-1:0] res;
   logic [7:0]         r888;
   logic [7:0]         g888;
   logic [7:0]         b888;
   logic [7:0]         r_ov;
   logic [7:0]         g_ov;
   logic [7:0]         b_ov;
   logic [7:0]         a_ov;

   assign en4 = !v4_ff || out_ready;
   assign en3 = !v3_ff || en4;
   assign in_ready = en3;
   assign out_valid = v4_ff;
   assign out_item = s4_ff;

   assign fmt = fmt_type'(s3_mode_ff[1:0]);
   assign merge = s3_mode_ff[MERGE_BIT];

   // sums stay within 255 * 255 since m + inv is 255
   assign r888 = div255(s3_ri_ff + s3_pr_ff);
   assign g888 = div255(s3_gi_ff + s3_pg_ff);
   assign b888 = div255(s3_bi_ff + s3_pb_ff);

   // source-over with each term floored on its own
   assign r_ov = sat255({1'b0, div255(s3_pr_ff)} + {1'b0, div255(s3_ri_ff)});
   assign g_ov = sat255({1'b0, div255(s3_pg_ff)} + {1'b0, div255(s3_gi_ff)});
   assign b_ov = sat255({1'b0, div255(s3_pb_ff)} + {1'b0, div255(s3_bi_ff)});
   assign a_ov = sat255({1'b0, s3_m_ff} + {1'b0, div255(s3_ai_ff)});

   always_comb begin
      res = '0;
      s4_in.changed = 1'b1;
      if (!merge) begin
         case (fmt)
            FMT_A8:       res = {24'd0, pen.alpha};
            FMT_RGB888:   res = {8'd0, pen.blue, pen.green, pen.red};
            FMT_RGBA4444: res = {16'd0, quant_pair(pen.blue, pen.alpha),
                                 quant_pair(pen.red, pen.green)};
            FMT_RGBA8888: res = {pen.alpha, pen.blue, pen.green, pen.red};
            default:      res = '0;
         endcase
      end else if (s3_skip_ff) begin
         res = s3_old_ff;
         s4_in.changed = 1'b0;
      end else begin
         case (fmt)
            FMT_A8:       res = {24'd0, s3_m_ff};
            FMT_RGB888:   res = {8'd0, b888, g888, r888};
            FMT_RGBA4444: res = {16'd0, quant_pair(pen.blue, s3_m_ff),
                                 quant_pair(pen.red, pen.green)};
            FMT_RGBA8888: begin
               // transparent target takes the pen color outright
               if (s3_old_ff[31:24] == 8'd0) begin
                  res = {s3_m_ff, pen.blue, pen.green, pen.red};
               end else begin
                  res = {a_ov, b_ov, g_ov, r_ov};
               end
            end
            default:      res = '0;
         endcase
      end
      s4_in.new_pixel = res & fmt_mask(fmt);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         if (en3) v3_ff <= in_valid;
         if (en4) v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en3 && in_valid) begin
         s3_mode_ff <= in_item.mode;
         s3_old_ff <= in_item.old_pixel;
         s3_skip_ff <= in_item.skip;
         s3_m_ff <= in_item.m;
         s3_pr_ff <= 16'(pen.red) * 16'(in_item.m);
         s3_pg_ff <= 16'(pen.green) * 16'(in_item.m);
         s3_pb_ff <= 16'(pen.blue) * 16'(in_item.m);
         s3_ri_ff <= 16'(in_item.old_pixel[7:0]) * 16'(in_item.inv);
         s3_gi_ff <= 16'(in_item.old_pixel[15:8]) * 16'(in_item.inv);
         s3_bi_ff <= 16'(in_item.old_pixel[23:16]) * 16'(in_item.inv);
         s3_ai_ff <= 16'(in_item.old_pixel[31:24]) * 16'(in_item.inv);
      end
      if (en4 && v3_ff) begin
         s4_ff <= s4_in;
      end
   end

endmodule
